// ===== hdl/mi3_pkg.sv =====
// Package with shared widths, payload structs and the cofactor index tables.
`timescale 1ns / 1ps
`default_nettype none
package mi3_pkg;

   // Entry format
   localparam int ENTRY_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int THR_W     = 16;
   localparam int NUM_ENTRY = 9;

   // Derived arithmetic widths
   localparam int PROD_W = 2 * ENTRY_W;          // entry x entry
   localparam int COF_W  = 2 * ENTRY_W + 1;      // difference of two products
   localparam int PART_W = 2 * ENTRY_W + 1;      // entry x cofactor slice
   localparam int DET_W  = 3 * ENTRY_W + 3;      // sum of three entry x cofactor
   localparam int NUM_W  = COF_W + 2 * FRAC_BITS; // scaled cofactor magnitude
   localparam int REM_W  = DET_W + ENTRY_W;      // divider remainder / shifted divisor

   typedef logic [3:0] idx_type;

   // adj[k] = m[A]*m[B] - m[C]*m[D], k = row*3 + col, m index = row*3 + col
   localparam idx_type COF_A [NUM_ENTRY] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
   localparam idx_type COF_B [NUM_ENTRY] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
   localparam idx_type COF_C [NUM_ENTRY] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
   localparam idx_type COF_D [NUM_ENTRY] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

   typedef logic [NUM_ENTRY-1:0][ENTRY_W-1:0] mat_type;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] entry_r0c0;
      logic signed [ENTRY_W-1:0] entry_r0c1;
      logic signed [ENTRY_W-1:0] entry_r0c2;
      logic signed [ENTRY_W-1:0] entry_r1c0;
      logic signed [ENTRY_W-1:0] entry_r1c1;
      logic signed [ENTRY_W-1:0] entry_r1c2;
      logic signed [ENTRY_W-1:0] entry_r2c0;
      logic signed [ENTRY_W-1:0] entry_r2c1;
      logic signed [ENTRY_W-1:0] entry_r2c2;
   } req_type;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] inverse_r0c0;
      logic signed [ENTRY_W-1:0] inverse_r0c1;
      logic signed [ENTRY_W-1:0] inverse_r0c2;
      logic signed [ENTRY_W-1:0] inverse_r1c0;
      logic signed [ENTRY_W-1:0] inverse_r1c1;
      logic signed [ENTRY_W-1:0] inverse_r1c2;
      logic signed [ENTRY_W-1:0] inverse_r2c0;
      logic signed [ENTRY_W-1:0] inverse_r2c1;
      logic signed [ENTRY_W-1:0] inverse_r2c2;
      logic                      near_singular;
      logic                      saturated;
   } rsp_type;

   // Front end result: shared divisor plus one numerator per lane
   typedef struct packed {
      logic                                valid;
      logic [DET_W-1:0]                    absdet;
      logic                                det_zero;
      logic [NUM_ENTRY-1:0][NUM_W-1:0]     num;
      logic [NUM_ENTRY-1:0]                neg;
   } front_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DET_W-1:0] div;
      logic             neg;
      logic             det_zero;
   } lane_in_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] quo;
      logic               ovf;
      logic               neg;
      logic               det_zero;
   } lane_out_type;

endpackage
`default_nettype wire

// ===== hdl/mi3_adj_det.sv =====
// Pipelined cofactor and determinant front end.
`timescale 1ns / 1ps
`default_nettype none
module mi3_adj_det import mi3_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  mat_type   in_mat,
   output front_type front
);

   logic [6:0] vld_ff;

   logic signed [ENTRY_W-1:0] m_ff      [NUM_ENTRY];
   logic signed [PROD_W-1:0]  prod_a_ff [NUM_ENTRY];
   logic signed [PROD_W-1:0]  prod_b_ff [NUM_ENTRY];
   logic signed [ENTRY_W-1:0] row0_b_ff [3];
   logic signed [ENTRY_W-1:0] row0_c_ff [3];
   logic signed [COF_W-1:0]   cof_c_ff  [NUM_ENTRY];
   logic signed [COF_W-1:0]   cof_d_ff  [NUM_ENTRY];
   logic signed [COF_W-1:0]   cof_e_ff  [NUM_ENTRY];
   logic signed [COF_W-1:0]   cof_f_ff  [NUM_ENTRY];
   logic signed [PART_W-1:0]  lo_ff     [3];
   logic signed [PART_W-1:0]  hi_ff     [3];
   logic signed [DET_W-1:0]   term_ff   [3];
   logic signed [DET_W-1:0]   det_ff;

   logic [DET_W-1:0]                absdet_ff;
   logic                            det_zero_ff;
   logic [NUM_ENTRY-1:0][NUM_W-1:0] num_ff;
   logic [NUM_ENTRY-1:0]            neg_ff;

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[5:0], in_valid};
      end
   end

   // input capture, products, cofactors
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_ENTRY; k++) begin
         m_ff[k]      <= $signed(in_mat[k]);
         prod_a_ff[k] <= PROD_W'(m_ff[COF_A[k]]) * PROD_W'(m_ff[COF_B[k]]);
         prod_b_ff[k] <= PROD_W'(m_ff[COF_C[k]]) * PROD_W'(m_ff[COF_D[k]]);
         cof_c_ff[k]  <= COF_W'(prod_a_ff[k]) - COF_W'(prod_b_ff[k]);
         cof_d_ff[k]  <= cof_c_ff[k];
         cof_e_ff[k]  <= cof_d_ff[k];
         cof_f_ff[k]  <= cof_e_ff[k];
      end
      for (int j = 0; j < 3; j++) begin
         row0_b_ff[j] <= m_ff[j];
         row0_c_ff[j] <= row0_b_ff[j];
      end
   end

   // determinant: row 0 times first cofactor column, split into two partials
   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         lo_ff[j] <= PART_W'(row0_c_ff[j])
                   * PART_W'($signed({1'b0, cof_c_ff[3*j][ENTRY_W-1:0]}));
         hi_ff[j] <= PART_W'(row0_c_ff[j])
                   * PART_W'($signed(cof_c_ff[3*j][COF_W-1:ENTRY_W]));
         term_ff[j] <= DET_W'(lo_ff[j]) + (DET_W'(hi_ff[j]) <<< ENTRY_W);
      end
      det_ff <= term_ff[0] + term_ff[1] + term_ff[2];
   end

   // magnitudes, signs and scaled numerators
   always_ff @(posedge clock) begin
      absdet_ff   <= det_ff[DET_W-1] ? DET_W'(-det_ff) : DET_W'(det_ff);
      det_zero_ff <= (det_ff == '0);
      for (int k = 0; k < NUM_ENTRY; k++) begin
         num_ff[k] <= (cof_f_ff[k][COF_W-1] ? NUM_W'(COF_W'(-cof_f_ff[k]))
                                            : NUM_W'(cof_f_ff[k])) << (2 * FRAC_BITS);
         neg_ff[k] <= cof_f_ff[k][COF_W-1] ^ det_ff[DET_W-1];
      end
   end

   assign front = '{valid:    vld_ff[6],
                    absdet:   absdet_ff,
                    det_zero: det_zero_ff,
                    num:      num_ff,
                    neg:      neg_ff};

endmodule
`default_nettype wire

// ===== hdl/mi3_div_lane.sv =====
// One pipelined restoring divider lane, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module mi3_div_lane import mi3_pkg::*; (
   input  logic         clock,
   input  lane_in_type  lane_in,
   output lane_out_type lane_out
);

   logic [REM_W-1:0]   rem_ff  [ENTRY_W+1];
   logic [REM_W-1:0]   div_ff  [ENTRY_W+1];
   logic [ENTRY_W-1:0] quo_ff  [ENTRY_W+1];
   logic               ovf_ff  [ENTRY_W+1];
   logic               neg_ff  [ENTRY_W+1];
   logic               zero_ff [ENTRY_W+1];

   // stage 0: quotient does not fit ENTRY_W bits when num >= div * 2^ENTRY_W
   always_ff @(posedge clock) begin
      rem_ff[0]  <= REM_W'(lane_in.num);
      div_ff[0]  <= REM_W'(lane_in.div);
      quo_ff[0]  <= '0;
      ovf_ff[0]  <= REM_W'(lane_in.num) >= (REM_W'(lane_in.div) << ENTRY_W);
      neg_ff[0]  <= lane_in.neg;
      zero_ff[0] <= lane_in.det_zero;
   end

   // quotient bits, most significant first
   for (genvar s = 1; s <= ENTRY_W; s++) begin : g_stage
      localparam int BIT = ENTRY_W - s;
      logic [REM_W:0]     diff;
      logic [REM_W-1:0]   rem_in;
      logic [ENTRY_W-1:0] quo_in;

      always_comb begin
         diff = {1'b0, rem_ff[s-1]} - {1'b0, div_ff[s-1] << BIT};
         if (!diff[REM_W]) begin
            rem_in = diff[REM_W-1:0];
            quo_in = quo_ff[s-1] | (ENTRY_W'(1) << BIT);
         end else begin
            rem_in = rem_ff[s-1];
            quo_in = quo_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         div_ff[s]  <= div_ff[s-1];
         quo_ff[s]  <= quo_in;
         ovf_ff[s]  <= ovf_ff[s-1];
         neg_ff[s]  <= neg_ff[s-1];
         zero_ff[s] <= zero_ff[s-1];
      end
   end

   assign lane_out = '{quo:      quo_ff[ENTRY_W],
                       ovf:      ovf_ff[ENTRY_W],
                       neg:      neg_ff[ENTRY_W],
                       det_zero: zero_ff[ENTRY_W]};

endmodule
`default_nettype wire

// ===== hdl/matrix_inverse_3x3_top.sv =====
// Top level: 3x3 fixed-point inverse, front end, nine divider lanes and merge.
// Pipeline from start to rsp_valid: 7 front-end stages, 33 divider stages (an overflow
// check, then one quotient bit per stage) and 1 merge/output stage.
// Throughput: one matrix per cycle; busy is never raised, the pipeline has no stall.
// Reset clears all valid bits and sets the near-singular threshold to 1.
// The receiver cannot stall: each result shows for exactly one cycle on rsp_valid.
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_3x3_top import mi3_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [THR_W-1:0] csr_data
);

   localparam int LAT = ENTRY_W + 9;

   logic [THR_W-1:0] thr_ff;
   mat_type          mat;
   front_type        front;
   lane_out_type     lane_out [NUM_ENTRY];
   logic             vld_ff   [ENTRY_W+1];
   logic             near_ff  [ENTRY_W+1];
   logic             near_in;
   logic [NUM_ENTRY-1:0][ENTRY_W-1:0] val_in;
   logic [NUM_ENTRY-1:0]              sat_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(1);
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_data;
      end
   end

   assign mat = {req_data.entry_r2c2, req_data.entry_r2c1, req_data.entry_r2c0,
                 req_data.entry_r1c2, req_data.entry_r1c1, req_data.entry_r1c0,
                 req_data.entry_r0c2, req_data.entry_r0c1, req_data.entry_r0c0};

   mi3_adj_det u_adj_det (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .in_mat   (mat),
      .front    (front)
   );

   // nine divider lanes sharing the determinant
   for (genvar k = 0; k < NUM_ENTRY; k++) begin : g_lane
      lane_in_type lane_in;
      assign lane_in = '{num:      front.num[k],
                         div:      front.absdet,
                         neg:      front.neg[k],
                         det_zero: front.det_zero};

      mi3_div_lane u_lane (
         .clock    (clock),
         .lane_in  (lane_in),
         .lane_out (lane_out[k])
      );
   end

   // near-singular test, exact in Q(3F) units
   assign near_in = front.absdet < (DET_W'(thr_ff) << (2 * FRAC_BITS));

   // valid and flag delay matching the divider lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= ENTRY_W; s++) vld_ff[s] <= 1'b0;
      end else begin
         vld_ff[0] <= front.valid;
         for (int s = 1; s <= ENTRY_W; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      near_ff[0] <= near_in;
      for (int s = 1; s <= ENTRY_W; s++) near_ff[s] <= near_ff[s-1];
   end

   // merge: saturate, apply sign, zero on singular
   always_comb begin
      logic [ENTRY_W-1:0] lim;
      logic [ENTRY_W-1:0] mag;
      logic               clip;
      for (int k = 0; k < NUM_ENTRY; k++) begin
         lim  = lane_out[k].neg ? (ENTRY_W'(1) << (ENTRY_W - 1))
                                : ((ENTRY_W'(1) << (ENTRY_W - 1)) - ENTRY_W'(1));
         clip = lane_out[k].ovf || (lane_out[k].quo > lim);
         mag  = clip ? lim : lane_out[k].quo;
         if (lane_out[k].det_zero) begin
            val_in[k] = '0;
            sat_in[k] = 1'b0;
         end else begin
            val_in[k] = lane_out[k].neg ? ENTRY_W'(-mag) : mag;
            sat_in[k] = clip;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[ENTRY_W];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff.inverse_r0c0  <= $signed(val_in[0]);
      rsp_ff.inverse_r0c1  <= $signed(val_in[1]);
      rsp_ff.inverse_r0c2  <= $signed(val_in[2]);
      rsp_ff.inverse_r1c0  <= $signed(val_in[3]);
      rsp_ff.inverse_r1c1  <= $signed(val_in[4]);
      rsp_ff.inverse_r1c2  <= $signed(val_in[5]);
      rsp_ff.inverse_r2c0  <= $signed(val_in[6]);
      rsp_ff.inverse_r2c1  <= $signed(val_in[7]);
      rsp_ff.inverse_r2c2  <= $signed(val_in[8]);
      rsp_ff.near_singular <= near_ff[ENTRY_W];
      rsp_ff.saturated     <= |sat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // every accepted matrix comes out after the fixed latency
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("result missing after fixed latency");

   // a clipped entry is never zero, so saturated implies some nonzero entry
   a_sat_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturated) |->
         (rsp_data.inverse_r0c0 != 0 || rsp_data.inverse_r0c1 != 0 ||
          rsp_data.inverse_r0c2 != 0 || rsp_data.inverse_r1c0 != 0 ||
          rsp_data.inverse_r1c1 != 0 || rsp_data.inverse_r1c2 != 0 ||
          rsp_data.inverse_r2c0 != 0 || rsp_data.inverse_r2c1 != 0 ||
          rsp_data.inverse_r2c2 != 0))
      else $error("saturated flag with all-zero inverse");

   // a zero threshold never flags a matrix
   a_thr_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && thr_ff == '0 && $stable(thr_ff)) |-> !rsp_data.near_singular)
      else $error("near_singular raised with zero threshold");
`endif

endmodule
`default_nettype wire
